### src/bfp_pkg.sv
// Shared constants, codes and job type for the byte FIFO with peek.
// No dependencies; every other file of the block imports this package.
package bfp_pkg;

    localparam int DEPTH_DEF     = 4096;
    localparam int ADD_BYTES_DEF = 8;
    localparam int MAX_READ_DEF  = 64;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 64;
    localparam int ALEN_W = 4;
    localparam int RLEN_W = 7;
    localparam int OFS_W  = 12;
    localparam int CNT_W  = 7;
    localparam int CAP_W  = 13;

    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;
    // reserved code: ignored, answered with one empty result
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_CAP_IDX = 1'b0;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_EMPTY
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] data;
    } job_t;

endpackage

### src/bfp_front.sv
// Front end: classify each item, commit head and fill, and build a job.
// Depends on bfp_pkg.
module bfp_front
    import bfp_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int ADD_BYTES = ADD_BYTES_DEF,
    parameter int MAX_READ  = MAX_READ_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [CAP_W-1:0]          cap,
    input  logic [CMD_W-1:0]          command,
    input  logic [DATA_W-1:0]         add_data,
    input  logic [ALEN_W-1:0]         add_length,
    input  logic [RLEN_W-1:0]         read_length,
    input  logic [OFS_W-1:0]          offset,
    input  logic                      partial,
    output job_t                      job,
    output logic [$clog2(DEPTH)-1:0]  job_addr
);

    localparam int PW  = $clog2(DEPTH);
    localparam int FW  = $clog2(DEPTH + 1);
    localparam int M1  = (FW > OFS_W) ? FW : OFS_W;
    localparam int M2  = (M1 > CAP_W) ? M1 : CAP_W;
    localparam int WW  = M2 + 1;

    logic [PW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic [WW-1:0] dep_w, cap_w, eff_w, fill_w, head_w, room;
    logic [WW-1:0] alen, take, tail;
    logic [WW-1:0] rlen, pos, len, start_sum, start_w, new_fill, adv_sum, adv_w;
    logic          rd_part, rd_empty, rd_short;

    always_comb
    begin
        dep_w  = WW'(DEPTH);
        cap_w  = WW'(cap);
        fill_w = WW'(fill_reg);
        head_w = WW'(head_reg);
        eff_w  = (cap_w > dep_w) ? dep_w : cap_w;
        room   = (eff_w > fill_w) ? (eff_w - fill_w) : '0;

        // add: saturate length, then fit into the free room
        alen = (WW'(add_length) > WW'(ADD_BYTES)) ? WW'(ADD_BYTES) : WW'(add_length);
        if ((room == '0) || (!partial && (alen > room)))
            take = '0;
        else
            take = (alen < room) ? alen : room;
        tail = head_w + fill_w;
        if (tail >= dep_w)
            tail = tail - dep_w;

        // peek / get
        rlen     = (WW'(read_length) > WW'(MAX_READ)) ? WW'(MAX_READ) : WW'(read_length);
        pos      = (command == CMD_GET) ? '0 : WW'(offset);
        rd_part  = (command == CMD_GET) ? partial : 1'b1;
        rd_short = (pos + rlen) > fill_w;
        rd_empty = (pos >= fill_w) || (rlen == '0) || (rd_short && !rd_part);
        len      = rd_short ? (fill_w - pos) : rlen;
        start_sum = head_w + pos;
        start_w   = (start_sum >= dep_w) ? (start_sum - dep_w) : start_sum;
        new_fill  = fill_w - len;
        adv_sum   = head_w + len;
        adv_w     = (adv_sum >= dep_w) ? (adv_sum - dep_w) : adv_sum;

        job.data  = add_data;
        job.op    = OP_EMPTY;
        job.cnt   = '0;
        job_addr  = '0;
        head_next = head_reg;
        fill_next = fill_reg;

        case (command)
            CMD_ADD:
            begin
                job.op    = OP_ADD;
                job.cnt   = CNT_W'(take);
                job_addr  = PW'(tail);
                fill_next = FW'(fill_w + take);
            end
            CMD_PEEK, CMD_GET:
            begin
                if (!rd_empty)
                begin
                    job.op   = OP_READ;
                    job.cnt  = CNT_W'(len);
                    job_addr = PW'(start_w);
                    if (command == CMD_GET)
                    begin
                        fill_next = FW'(new_fill);
                        head_next = (new_fill == '0) ? '0 : PW'(adv_w);
                    end
                end
            end
            default:
            begin
                job.op = OP_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

endmodule

### src/bfp_queue.sv
// Two-entry job queue between front and back end.
// Depends on bfp_pkg for job_t, whose width is the default of W.
module bfp_queue
    import bfp_pkg::*;
#(
    parameter int W = $bits(job_t)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head_data,
    output logic         not_empty,
    output logic         full
);

    logic [W-1:0] slot_reg [2];
    logic         wr_reg, rd_reg;
    logic [1:0]   num_reg;

    assign full      = (num_reg == 2'd2);
    assign not_empty = (num_reg != 2'd0);
    assign head_data = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            num_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= ~wr_reg;
            if (pop && not_empty)
                rd_reg <= ~rd_reg;
            num_reg <= num_reg + {1'b0, (push && !full)} - {1'b0, (pop && not_empty)};
        end
    end

endmodule

### src/bfp_back.sv
// Back end: owns the byte store, writes added bytes, streams read bytes.
// Depends on bfp_pkg.
module bfp_back
    import bfp_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    input  job_t                      job,
    input  logic [$clog2(DEPTH)-1:0]  job_addr,
    output logic                      job_pop,
    output logic                      result_valid,
    output logic [7:0]                data_byte,
    output logic                      byte_valid,
    output logic [CNT_W-1:0]          count,
    output logic                      last
);

    localparam int PW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_READ
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     addr_reg, addr_next, addr_inc;
    logic [CNT_W-1:0]  idx_reg, idx_next, cnt_reg, cnt_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              res_v_reg, res_v_next, res_bv_reg, res_bv_next;
    logic              res_last_reg, res_last_next;
    logic [CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic              we, re, at_end;
    logic [7:0]        wdata, rdata_reg;
    logic [7:0]        mem [DEPTH];

    assign addr_inc = (addr_reg == PW'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
    assign at_end   = (idx_reg == cnt_reg - 1'b1);
    assign wdata    = data_reg[{idx_reg[2:0], 3'b000} +: 8];

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        data_next     = data_reg;
        job_pop       = 1'b0;
        we            = 1'b0;
        re            = 1'b0;
        res_v_next    = 1'b0;
        res_bv_next   = 1'b0;
        res_last_next = 1'b0;
        res_cnt_next  = res_cnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    addr_next = job_addr;
                    cnt_next  = job.cnt;
                    data_next = job.data;
                    idx_next  = '0;
                    case (job.op)
                        OP_ADD:
                        begin
                            if (job.cnt == '0)
                            begin
                                res_v_next    = 1'b1;
                                res_last_next = 1'b1;
                                res_cnt_next  = '0;
                            end
                            else
                                state_next = S_ADD;
                        end
                        OP_READ:
                            state_next = S_READ;
                        default:
                        begin
                            res_v_next    = 1'b1;
                            res_last_next = 1'b1;
                            res_cnt_next  = '0;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                we        = 1'b1;
                addr_next = addr_inc;
                idx_next  = idx_reg + 1'b1;
                if (at_end)
                begin
                    res_v_next    = 1'b1;
                    res_last_next = 1'b1;
                    res_cnt_next  = cnt_reg;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                re            = 1'b1;
                addr_next     = addr_inc;
                idx_next      = idx_reg + 1'b1;
                res_v_next    = 1'b1;
                res_bv_next   = 1'b1;
                res_cnt_next  = cnt_reg;
                res_last_next = at_end;
                if (at_end)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr_reg] <= wdata;
        if (re)
            rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            addr_reg     <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            data_reg     <= '0;
            res_v_reg    <= 1'b0;
            res_bv_reg   <= 1'b0;
            res_last_reg <= 1'b0;
            res_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            data_reg     <= data_next;
            res_v_reg    <= res_v_next;
            res_bv_reg   <= res_bv_next;
            res_last_reg <= res_last_next;
            res_cnt_reg  <= res_cnt_next;
        end
    end

    assign result_valid = res_v_reg;
    assign byte_valid   = res_bv_reg;
    assign data_byte    = res_bv_reg ? rdata_reg : 8'h00;
    assign count        = res_cnt_reg;
    assign last         = res_last_reg;

endmodule

### src/byte_fifo_with_peek_core.sv
// Top level of the byte FIFO with peek: APB register, front end, job queue, back end.
// Depends on bfp_pkg, bfp_front, bfp_queue and bfp_back.
//
// Usage: drive an item with start while busy is low; it is taken at that edge. The
// front end settles each item at once (bytes accepted, bytes to return, new head and
// fill) and hands a job to a two-entry queue, so busy rises only when two jobs wait.
// The back end works one job at a time on the single-port byte store of DEPTH bytes:
// an add of n accepted bytes writes one byte a cycle, a peek or get of n bytes reads
// one byte a cycle, and an item that moves no byte answers straight from idle.
// Results come in the cycle after the back end produces them, one per cycle,
// each on the result ports for exactly one cycle with result_valid high; the receiver
// cannot hold them off, so take every strobe. A read item gives one result per byte,
// last on the final one; an add, or any item that returns nothing, gives one result
// with byte_valid low. No clearing pass runs after reset: bytes are read only after
// they were written. Write capacity_limit (address 0) only while no item is pending.
module byte_fifo_with_peek_core
    import bfp_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int ADD_BYTES = ADD_BYTES_DEF,
    parameter int MAX_READ  = MAX_READ_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // item channel
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [DATA_W-1:0] add_data,
    input  logic [ALEN_W-1:0] add_length,
    input  logic [RLEN_W-1:0] read_length,
    input  logic [OFS_W-1:0]  offset,
    input  logic              partial,
    // result channel
    output logic              result_valid,
    output logic [7:0]        data_byte,
    output logic              byte_valid,
    output logic [CNT_W-1:0]  count,
    output logic              last,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int PW = $clog2(DEPTH);
    localparam int QW = $bits(job_t) + PW;

    logic [CAP_W-1:0] cap_reg;
    logic             accept;
    job_t             front_job, back_job;
    logic [PW-1:0]    front_addr, back_addr;
    logic [QW-1:0]    q_head;
    logic             q_not_empty, q_pop;

    // Register file: one register, capacity_limit.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAP_IDX) ? 32'(cap_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAP_IDX))
            cap_reg <= pwdata[CAP_W-1:0];
    end

    // Take an item whenever the queue has room.
    assign accept = start && !busy;

    bfp_front #(
        .DEPTH     (DEPTH),
        .ADD_BYTES (ADD_BYTES),
        .MAX_READ  (MAX_READ)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cap         (cap_reg),
        .command     (command),
        .add_data    (add_data),
        .add_length  (add_length),
        .read_length (read_length),
        .offset      (offset),
        .partial     (partial),
        .job         (front_job),
        .job_addr    (front_addr)
    );

    bfp_queue #(
        .W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data ({front_addr, front_job}),
        .pop       (q_pop),
        .head_data (q_head),
        .not_empty (q_not_empty),
        .full      (busy)
    );

    assign back_job  = q_head[$bits(job_t)-1:0];
    assign back_addr = q_head[QW-1:$bits(job_t)];

    bfp_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (q_not_empty),
        .job          (back_job),
        .job_addr     (back_addr),
        .job_pop      (q_pop),
        .result_valid (result_valid),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .count        (count),
        .last         (last)
    );

    // A result that carries no byte is always the only result of its item.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !byte_valid |-> last)
        else $error("result without byte is not marked last");

    // Read bytes stream without gaps until the last one.
    a_read_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && byte_valid && !last |=> result_valid && byte_valid)
        else $error("gap inside a read burst");

    // A returned byte always belongs to a transfer of at least one byte.
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && byte_valid |-> count != '0)
        else $error("byte returned with zero count");

    // The count holds steady across one read burst.
    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && byte_valid && !last |=> $stable(count))
        else $error("count changed inside a read burst");

endmodule

### test/byte_fifo_with_peek_core_tb.sv
// Self-checking testbench for byte_fifo_with_peek_core: drives add, peek and get items
// and predicts every result from a mirror of the ring store. Needs only bfp_pkg and the RTL.
`timescale 1ns / 1ps

module byte_fifo_with_peek_core_tb;
    import bfp_pkg::*;

    // capacity_limit sits at register index 0, byte address 0
    localparam logic [2:0] CAP_ADDR = {REG_CAP_IDX, 2'b00};

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] add_data;
        logic [ALEN_W-1:0] add_length;
        logic [RLEN_W-1:0] read_length;
        logic [OFS_W-1:0]  offset;
        logic              partial;
    } fifo_item_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             byte_valid;
        logic [CNT_W-1:0] count;
        logic             last;
    } fifo_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              start = 1'b0;
    logic              busy;
    logic [CMD_W-1:0]  command = '0;
    logic [DATA_W-1:0] add_data = '0;
    logic [ALEN_W-1:0] add_length = '0;
    logic [RLEN_W-1:0] read_length = '0;
    logic [OFS_W-1:0]  offset = '0;
    logic              partial = 1'b0;

    logic              result_valid;
    logic [7:0]        data_byte;
    logic              byte_valid;
    logic [CNT_W-1:0]  count;
    logic              last;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    byte_fifo_with_peek_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .add_data     (add_data),
        .add_length   (add_length),
        .read_length  (read_length),
        .offset       (offset),
        .partial      (partial),
        .result_valid (result_valid),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .count        (count),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the FIFO: ring store, head, fill and capacity register.
    // Only entries inside the fill are ever read, and those were written.
    // ------------------------------------------------------------------
    logic [7:0]     mirror_store [0:DEPTH_DEF-1];
    int             mirror_head = 0;
    int             mirror_fill = 0;
    int             mirror_cap  = int'(CAP_RESET);

    fifo_result_t   due_results [$];
    fifo_item_t     item_backlog [$];
    int             fail_count = 0;

    // accept flag sampled at the rising edge, read by the driver at the falling edge
    logic           taken = 1'b0;

    task automatic owe_result(input int b, input int v, input int cnt, input int lst);
        fifo_result_t r;
        r.data_byte  = 8'(b);
        r.byte_valid = 1'(v);
        r.count      = CNT_W'(cnt);
        r.last       = 1'(lst);
        due_results.push_back(r);
    endtask

    // Apply one accepted item to the mirror and queue the results it owes.
    task automatic apply_to_mirror(input fifo_item_t it);
        int cap;
        int n;
        int room;
        int take;
        int len;
        int pos;
        bit may_shorten;
        cap = (mirror_cap < DEPTH_DEF) ? mirror_cap : DEPTH_DEF;
        case (it.command)
            CMD_ADD:
            begin
                n = (it.add_length > ADD_BYTES_DEF) ? ADD_BYTES_DEF : int'(it.add_length);
                room = (cap > mirror_fill) ? cap - mirror_fill : 0;
                // full buffer, or a strict add that does not fit, takes nothing
                if (room == 0 || (!it.partial && n > room))
                    take = 0;
                else
                    take = (n < room) ? n : room;
                for (int i = 0; i < take; i++)
                    mirror_store[(mirror_head + mirror_fill + i) % DEPTH_DEF] =
                        it.add_data[8*i +: 8];
                mirror_fill += take;
                owe_result(0, 0, take, 1);
            end
            CMD_PEEK, CMD_GET:
            begin
                len = (it.read_length > MAX_READ_DEF) ? MAX_READ_DEF : int'(it.read_length);
                pos = (it.command == CMD_GET) ? 0 : int'(it.offset);
                may_shorten = (it.command == CMD_GET) ? it.partial : 1'b1;
                if (pos >= mirror_fill || len == 0)
                    owe_result(0, 0, 0, 1);
                else if (pos + len > mirror_fill && !may_shorten)
                    owe_result(0, 0, 0, 1);
                else
                begin
                    if (pos + len > mirror_fill)
                        len = mirror_fill - pos;
                    for (int i = 0; i < len; i++)
                        owe_result(mirror_store[(mirror_head + pos + i) % DEPTH_DEF], 1, len,
                                   (i + 1 == len) ? 1 : 0);
                    if (it.command == CMD_GET)
                    begin
                        mirror_fill -= len;
                        // an emptied buffer restarts at slot zero
                        mirror_head = (mirror_fill != 0) ? (mirror_head + len) % DEPTH_DEF : 0;
                    end
                end
            end
            default:
                owe_result(0, 0, 0, 1);
        endcase
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, what, want, want, got, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: check each strobed result against the oldest expectation,
    // then feed the item accepted at this edge to the mirror.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        fifo_result_t want;
        fifo_item_t   seen;
        if (!rst_n)
            taken <= 1'b0;
        else
        begin
            taken <= start && !busy;
            if (result_valid)
            begin
                if (due_results.size() == 0)
                begin
                    $display({"%0t ns: result with no item awaiting it, expected none, ",
                              "actual %0h/%0d/%0d/%0d"},
                             $time, data_byte, byte_valid, count, last);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("byte_valid", want.byte_valid, byte_valid);
                    check_field("count", want.count, count);
                    check_field("last", want.last, last);
                end
            end
            if (start && !busy)
            begin
                seen.command     = command;
                seen.add_data    = add_data;
                seen.add_length  = add_length;
                seen.read_length = read_length;
                seen.offset      = offset;
                seen.partial     = partial;
                apply_to_mirror(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: present items from the backlog in bursts with random gaps.
    // Hold an item until it is taken; advance at the next falling edge.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        fifo_item_t nxt;
        if (rst_n && !(start && !taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (item_backlog.size() > 0)
            begin
                nxt = item_backlog.pop_front();
                start       <= 1'b1;
                command     <= nxt.command;
                add_data    <= nxt.add_data;
                add_length  <= nxt.add_length;
                read_length <= nxt.read_length;
                offset      <= nxt.offset;
                partial     <= nxt.partial;
                if (burst_left <= 1)
                begin
                    // a third of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus. The generator keeps a rough fill estimate of its own so
    // that offsets and lengths land near the interesting boundaries.
    // ------------------------------------------------------------------
    int est_fill = 0;
    int gen_cap  = int'(CAP_RESET);

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data,
                              input int alen, input int rlen, input int ofs, input bit part);
        fifo_item_t it;
        int cap;
        int n;
        int room;
        it.command     = cmd;
        it.add_data    = data;
        it.add_length  = ALEN_W'(alen);
        it.read_length = RLEN_W'(rlen);
        it.offset      = OFS_W'(ofs);
        it.partial     = part;
        item_backlog.push_back(it);
        cap = (gen_cap < DEPTH_DEF) ? gen_cap : DEPTH_DEF;
        if (cmd == CMD_ADD)
        begin
            n = (alen > ADD_BYTES_DEF) ? ADD_BYTES_DEF : alen;
            room = (cap > est_fill) ? cap - est_fill : 0;
            if (room > 0 && (part || n <= room))
                est_fill += (n < room) ? n : room;
        end
        else if (cmd == CMD_GET)
        begin
            n = (rlen > MAX_READ_DEF) ? MAX_READ_DEF : rlen;
            if (n > 0 && est_fill > 0 && (part || n <= est_fill))
                est_fill -= (n < est_fill) ? n : est_fill;
        end
    endtask

    task automatic queue_random_item(input int add_pct);
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data;
        int alen;
        int rlen;
        int ofs;
        int sel;
        int pick;
        bit part;
        // randomize every field, then shape the ones the command uses
        data = {$urandom, $urandom};
        alen = $urandom_range(0, 15);
        rlen = $urandom_range(0, 127);
        ofs  = $urandom_range(0, 4095);
        part = 1'($urandom_range(0, 1));
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (sel < add_pct)
        begin
            cmd = CMD_ADD;
            if (pick == 0)
                alen = 0;
            else if (pick > 1)
                alen = $urandom_range(1, ADD_BYTES_DEF);
        end
        else if (sel < add_pct + (100 - add_pct) * 4 / 9)
        begin
            cmd = CMD_PEEK;
            if (pick == 0)
                rlen = 0;
            else if (pick < 8)
                rlen = $urandom_range(1, 24);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                ofs = est_fill;
            else if (sel < 8 && est_fill > 0)
                ofs = $urandom_range(0, est_fill - 1);
        end
        else if (sel < 96)
        begin
            cmd = CMD_GET;
            if (pick == 0)
                rlen = 0;
            else if (pick == 1 && est_fill > 0)
                rlen = (est_fill > 127) ? MAX_READ_DEF : est_fill;
            else if (pick < 8)
                rlen = $urandom_range(1, 16);
        end
        else
            cmd = CMD_UNUSED;
        queue_item(cmd, data, alen, rlen, ofs, part);
    endtask

    task automatic apb_cycle(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CAP_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write capacity_limit, update the mirror, read it back.
    task automatic write_capacity(input int value);
        logic [31:0] word;
        logic [31:0] rd;
        word = $urandom;
        word[CAP_W-1:0] = CAP_W'(value);
        apb_cycle(1'b1, word, rd);
        mirror_cap = int'(word[CAP_W-1:0]);
        gen_cap    = mirror_cap;
        apb_cycle(1'b0, 32'd0, rd);
        check_field("capacity_limit", mirror_cap, int'(rd[CAP_W-1:0]));
    endtask

    // Hold the sender until every item is taken and every result is back.
    // Look just after the falling edge, once the driver's update has settled.
    task automatic wait_for_idle();
        while (item_backlog.size() != 0 || start || due_results.size() != 0)
        begin
            @(negedge clk);
            #1;
        end
    endtask

    task automatic run_phase(input int cap, input int items, input int add_pct);
        wait_for_idle();
        write_capacity(cap);
        repeat (items)
            queue_random_item(add_pct);
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the reset capacity
        queue_item(CMD_GET, '0, 0, 5, 0, 1'b1);                     // get on empty
        queue_item(CMD_PEEK, '0, 0, 5, 0, 1'b1);                    // peek on empty
        queue_item(CMD_ADD, {$urandom, $urandom}, 0, 0, 0, 1'b0);   // add of zero bytes
        queue_item(CMD_ADD, '1, 8, 0, 0, 1'b0);
        queue_item(CMD_ADD, 64'h0123_4567_89AB_CDEF, 15, 0, 0, 1'b0); // length saturates
        queue_item(CMD_PEEK, '0, 0, 0, 0, 1'b1);                    // zero length
        queue_item(CMD_PEEK, '0, 0, 4, 16, 1'b0);                   // offset at fill
        queue_item(CMD_PEEK, '0, 0, 4, 4095, 1'b0);                 // largest offset
        queue_item(CMD_PEEK, '0, 0, 127, 3, 1'b0);                  // long read, shortened
        queue_item(CMD_GET, '0, 0, 20, 0, 1'b0);                    // strict get runs short
        queue_item(CMD_GET, '0, 0, 4, 0, 1'b1);
        queue_item(CMD_UNUSED, '1, 15, 127, 4095, 1'b1);            // unknown command code
        queue_item(CMD_PEEK, '0, 0, 64, 0, 1'b0);
        queue_item(CMD_GET, '0, 0, 127, 0, 1'b1);                   // empties the buffer
        queue_item(CMD_ADD, '0, 8, 0, 0, 1'b0);
        queue_item(CMD_GET, '0, 0, 8, 0, 1'b0);                     // exact strict get

        // directed part at the smallest capacity
        wait_for_idle();
        write_capacity(1);
        queue_item(CMD_ADD, {$urandom, $urandom}, 8, 0, 0, 1'b0);   // does not fit
        queue_item(CMD_ADD, {$urandom, $urandom}, 8, 0, 0, 1'b1);   // one byte fits
        queue_item(CMD_ADD, {$urandom, $urandom}, 1, 0, 0, 1'b1);   // buffer full
        queue_item(CMD_PEEK, '0, 0, 1, 0, 1'b0);
        queue_item(CMD_GET, '0, 0, 2, 0, 1'b0);
        queue_item(CMD_GET, '0, 0, 1, 0, 1'b0);

        // random phases; fill carries over, so a lowered capacity can sit below it
        run_phase(8191, 80, 70);
        run_phase(40, 78, 45);
        run_phase(0, 70, 30);
        run_phase(5, 78, 45);
        run_phase(4096, 80, 50);
        run_phase($urandom_range(1, 300), 80, 50);

        wait_for_idle();
        // let the longest job time out so any stray result is caught
        repeat (80)
            @(negedge clk);
        if (fail_count == 0)
            $display("[byte_fifo_with_peek_core] OK");
        else
            $display("[byte_fifo_with_peek_core] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[byte_fifo_with_peek_core] ERROR");
        $finish;
    end

endmodule
